FILE: rtl/ism_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ism_pkg: shared types and constants for the ising metropolis update block
// Field widths, register indexes, item codes and the structs that pass
// between the configuration bank, the update logic and the top level.
// ----------------------------------------------------------------------------
package ism_pkg;

    // parameter defaults
    localparam int SIDE_MAX_DEF  = 64;
    localparam int DRAW_BITS_DEF = 16;

    // fixed field widths
    localparam int ROW_W        = 6;
    localparam int DRAW_W       = 16;
    localparam int ROWS_W       = 7;
    localparam int COEF_W       = 16;
    localparam int THR_W        = 17;
    localparam int NUM_THR      = 10;
    localparam int CNT_W        = 13;
    localparam int ENERGY_W     = 40;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 51;
    localparam int IN_TDATA_W   = 32;
    localparam int OUT_TDATA_W  = 56;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_J      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_LO = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_MI = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_HI = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_9  = 3'd6;

    // item kinds
    localparam logic KIND_ATTEMPT = 1'b0;
    localparam logic KIND_SET     = 1'b1;

    // reset values
    localparam logic [ROWS_W-1:0]        ROWS_RST = 7'd64;
    localparam logic signed [COEF_W-1:0] J_RST    = 16'sd256;

    // accumulator limits
    localparam logic signed [ENERGY_W-1:0] E_MAX = {1'b0, {(ENERGY_W-1){1'b1}}};
    localparam logic signed [ENERGY_W-1:0] E_MIN = {1'b1, {(ENERGY_W-1){1'b0}}};

    typedef struct packed {
        logic signed [COEF_W-1:0]         coupling_j;
        logic signed [COEF_W-1:0]         field_b;
        logic [NUM_THR-1:0][THR_W-1:0]    thr;
    } ism_cfg_t;

    typedef struct packed {
        logic              kind;
        logic [ROW_W-1:0]  row;
        logic [ROW_W-1:0]  col;
        logic [DRAW_W-1:0] random_draw;
        logic              spin_value;
    } ism_item_t;

    typedef struct packed {
        logic                       flipped;
        logic                       new_spin;
        logic [CNT_W-1:0]           down_count;
        logic signed [ENERGY_W-1:0] energy_change;
        logic                       site_error;
    } ism_result_t;

endpackage
`default_nettype wire

FILE: rtl/ising_metropolis_update_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ising_metropolis_update_top: 2d ising lattice with metropolis updates
// Holds the spin lattice in three row ram copies, takes attempt and set
// words and returns one result word per input word.
//
//   channel   dir  handshake                    contents
//   s_axis    in   s_axis_tvalid/s_axis_tready  site, draw, forced spin; tuser kind
//   m_axis    out  m_axis_tvalid/m_axis_tready  flip, spin, count, energy; tuser error
//   cfg       in   cfg_valid/cfg_ready          register index and data
//
// One word per cycle sustained while m_axis is not stalled; a result passes through
// the input register and the result register before it is valid on m_axis.
// The three neighbour rows come from three ram copies read in the same cycle,
// a write to the row just read is forwarded from a bypass register.
// Reset is asynchronous; row valid bits make every spin read as +1, no sweep.
// A stalled m_axis holds the update stage and the input register keeps taking
// one more word.
// ----------------------------------------------------------------------------
module ising_metropolis_update_top #(
    parameter int SIDE_MAX  = ism_pkg::SIDE_MAX_DEF,
    parameter int DRAW_BITS = ism_pkg::DRAW_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // row[5:0], col[11:6], random_draw[27:12], spin_value[28], zero fill
    input  wire logic [ism_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // kind[0]
    input  wire logic [0:0]                         s_axis_tuser,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // flipped[0], new_spin[1], down_count[14:2], energy_change[54:15], zero fill
    output logic      [ism_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // site_error[0]
    output logic      [0:0]                         m_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [ism_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [ism_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import ism_pkg::*;

    localparam int IDX_W  = $clog2(SIDE_MAX);
    localparam int SIDE_W = $clog2(SIDE_MAX + 1);

    logic [SIDE_W-1:0]      side;
    ism_cfg_t               cfg;
    ism_item_t              in_item;
    ism_item_t              item_reg;
    logic                   s1_vld_reg;
    logic [IDX_W-1:0]       up_idx_reg;
    logic [IDX_W-1:0]       mid_idx_reg;
    logic [IDX_W-1:0]       dn_idx_reg;
    logic [IDX_W-1:0]       in_mid;
    logic [IDX_W-1:0]       in_up;
    logic [IDX_W-1:0]       in_dn;
    logic                   in_accept;
    logic                   s1_fire;
    logic                   m_vld_reg;
    logic                   m_vld_next;
    ism_result_t            res_reg;
    ism_result_t            result;
    logic [SIDE_MAX-1:0]    up_q;
    logic [SIDE_MAX-1:0]    mid_q;
    logic [SIDE_MAX-1:0]    dn_q;
    logic                   row_we;
    logic [IDX_W-1:0]       row_waddr;
    logic [SIDE_MAX-1:0]    row_wdata;

    // configuration bank
    ism_cfg #(
        .SIDE_MAX (SIDE_MAX)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .side      (side),
        .cfg       (cfg)
    );

    // input word unpack
    assign in_item.kind        = s_axis_tuser[0];
    assign in_item.row         = s_axis_tdata[5:0];
    assign in_item.col         = s_axis_tdata[11:6];
    assign in_item.random_draw = s_axis_tdata[27:12];
    assign in_item.spin_value  = s_axis_tdata[28];

    // handshake
    assign s1_fire       = s1_vld_reg && (!m_vld_reg || m_axis_tready);
    assign s_axis_tready = !s1_vld_reg || s1_fire;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // row addresses with wrap
    assign in_mid = IDX_W'(in_item.row);
    assign in_up  = (in_mid == '0) ? IDX_W'(side - SIDE_W'(1)) : in_mid - IDX_W'(1);
    assign in_dn  = (SIDE_W'(in_mid) + SIDE_W'(1) == side) ? '0 : in_mid + IDX_W'(1);

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            s1_vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg    <= in_item;
            up_idx_reg  <= in_up;
            mid_idx_reg <= in_mid;
            dn_idx_reg  <= in_dn;
        end
    end

    // three lattice copies, one read port each
    ism_ram #(
        .WIDTH (SIDE_MAX),
        .DEPTH (SIDE_MAX)
    ) u_ram_up (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .re    (in_accept),
        .raddr (in_up),
        .rdata (up_q)
    );

    ism_ram #(
        .WIDTH (SIDE_MAX),
        .DEPTH (SIDE_MAX)
    ) u_ram_mid (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .re    (in_accept),
        .raddr (in_mid),
        .rdata (mid_q)
    );

    ism_ram #(
        .WIDTH (SIDE_MAX),
        .DEPTH (SIDE_MAX)
    ) u_ram_dn (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .re    (in_accept),
        .raddr (in_dn),
        .rdata (dn_q)
    );

    // update datapath
    ism_update #(
        .SIDE_MAX  (SIDE_MAX),
        .DRAW_BITS (DRAW_BITS)
    ) u_update (
        .clk       (clk),
        .rst_n     (rst_n),
        .side      (side),
        .cfg       (cfg),
        .fire      (s1_fire),
        .item      (item_reg),
        .up_idx    (up_idx_reg),
        .mid_idx   (mid_idx_reg),
        .dn_idx    (dn_idx_reg),
        .up_q      (up_q),
        .mid_q     (mid_q),
        .dn_q      (dn_q),
        .row_we    (row_we),
        .row_waddr (row_waddr),
        .row_wdata (row_wdata),
        .result    (result)
    );

    // result register
    always_comb
    begin
        if (s1_fire)
            m_vld_next = 1'b1;
        else if (m_axis_tready)
            m_vld_next = 1'b0;
        else
            m_vld_next = m_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_vld_reg <= 1'b0;
        end
        else
        begin
            m_vld_reg <= m_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            res_reg <= result;
        end
    end

    // output word pack
    assign m_axis_tvalid = m_vld_reg;
    assign m_axis_tdata  = {1'b0, res_reg.energy_change, res_reg.down_count,
                            res_reg.new_spin, res_reg.flipped};
    assign m_axis_tuser  = res_reg.site_error;

`ifndef SYNTHESIS
    // an update always lands in the result register
    a_fire_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> m_vld_reg)
        else $error("update fired without a result word");

    // the lattice is only written by a firing update
    a_we_fire: assert property (@(posedge clk) disable iff (!rst_n)
        row_we |-> s1_fire)
        else $error("lattice write outside an update");

    // an error word reports no flip and a zero spin
    a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_vld_reg && res_reg.site_error |-> !res_reg.flipped && !res_reg.new_spin)
        else $error("error word carries a flip or spin");
`endif

endmodule
`default_nettype wire

FILE: rtl/ism_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ism_ram: generic single-write, single-read ram
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ism_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

FILE: rtl/ism_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ism_cfg: configuration register bank
// Holds side length, coupling, field and the ten acceptance thresholds,
// and clamps the side length to the supported range.
// ----------------------------------------------------------------------------
module ism_cfg #(
    parameter int SIDE_MAX = ism_pkg::SIDE_MAX_DEF,
    localparam int SIDE_W = $clog2(SIDE_MAX + 1)
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [ism_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [ism_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic      [SIDE_W-1:0]                  side,
    output ism_pkg::ism_cfg_t                       cfg
);
    import ism_pkg::*;

    localparam int CW = (SIDE_W > ROWS_W) ? SIDE_W : ROWS_W;

    logic [ROWS_W-1:0]              rows_reg;
    logic signed [COEF_W-1:0]       j_reg;
    logic signed [COEF_W-1:0]       b_reg;
    logic [NUM_THR-1:0][THR_W-1:0]  thr_reg;
    logic                           wr;
    logic [CW-1:0]                  rows_ext;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;

    // register writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= ROWS_RST;
            j_reg    <= J_RST;
            b_reg    <= '0;
            thr_reg  <= '0;
        end
        else if (wr)
        begin
            case (cfg_index)
                CFG_ROWS:   rows_reg <= cfg_data[ROWS_W-1:0];
                CFG_J:      j_reg    <= cfg_data[COEF_W-1:0];
                CFG_B:      b_reg    <= cfg_data[COEF_W-1:0];
                CFG_THR_LO:
                begin
                    thr_reg[0] <= cfg_data[0*THR_W +: THR_W];
                    thr_reg[1] <= cfg_data[1*THR_W +: THR_W];
                    thr_reg[2] <= cfg_data[2*THR_W +: THR_W];
                end
                CFG_THR_MI:
                begin
                    thr_reg[3] <= cfg_data[0*THR_W +: THR_W];
                    thr_reg[4] <= cfg_data[1*THR_W +: THR_W];
                    thr_reg[5] <= cfg_data[2*THR_W +: THR_W];
                end
                CFG_THR_HI:
                begin
                    thr_reg[6] <= cfg_data[0*THR_W +: THR_W];
                    thr_reg[7] <= cfg_data[1*THR_W +: THR_W];
                    thr_reg[8] <= cfg_data[2*THR_W +: THR_W];
                end
                CFG_THR_9:  thr_reg[9] <= cfg_data[THR_W-1:0];
                default:    rows_reg <= rows_reg;
            endcase
        end
    end

    // side length clamp
    assign rows_ext = CW'(rows_reg);
    always_comb
    begin
        if (rows_ext < CW'(2))
        begin
            side = SIDE_W'(2);
        end
        else if (rows_ext > CW'(SIDE_MAX))
        begin
            side = SIDE_W'(SIDE_MAX);
        end
        else
        begin
            side = SIDE_W'(rows_ext);
        end
    end

    assign cfg.coupling_j = j_reg;
    assign cfg.field_b    = b_reg;
    assign cfg.thr        = thr_reg;

endmodule
`default_nettype wire

FILE: rtl/ism_update.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ism_update: spin update datapath
// Resolves the three lattice rows (row valid bits and last-write bypass),
// makes the flip decision, and keeps the down count and energy sum.
// ----------------------------------------------------------------------------
module ism_update #(
    parameter int SIDE_MAX  = ism_pkg::SIDE_MAX_DEF,
    parameter int DRAW_BITS = ism_pkg::DRAW_BITS_DEF,
    localparam int IDX_W  = $clog2(SIDE_MAX),
    localparam int SIDE_W = $clog2(SIDE_MAX + 1)
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [SIDE_W-1:0]      side,
    input  wire ism_pkg::ism_cfg_t      cfg,
    input  wire logic                   fire,
    input  wire ism_pkg::ism_item_t     item,
    input  wire logic [IDX_W-1:0]       up_idx,
    input  wire logic [IDX_W-1:0]       mid_idx,
    input  wire logic [IDX_W-1:0]       dn_idx,
    input  wire logic [SIDE_MAX-1:0]    up_q,
    input  wire logic [SIDE_MAX-1:0]    mid_q,
    input  wire logic [SIDE_MAX-1:0]    dn_q,
    output logic                        row_we,
    output logic      [IDX_W-1:0]       row_waddr,
    output logic      [SIDE_MAX-1:0]    row_wdata,
    output ism_pkg::ism_result_t        result
);
    import ism_pkg::*;

    localparam int CMP_W = (SIDE_W > ROW_W) ? SIDE_W : ROW_W;
    localparam logic [DRAW_W-1:0] DRAW_MASK =
        DRAW_W'((64'd1 << DRAW_BITS) - 64'd1);

    logic [SIDE_MAX-1:0]        vld_reg;
    logic                       byp_vld_reg;
    logic [IDX_W-1:0]           byp_addr_reg;
    logic [SIDE_MAX-1:0]        byp_data_reg;
    logic [CNT_W-1:0]           down_reg;
    logic [CNT_W-1:0]           down_next;
    logic signed [ENERGY_W-1:0] energy_reg;
    logic signed [ENERGY_W-1:0] energy_next;

    logic [SIDE_MAX-1:0]        up_row;
    logic [SIDE_MAX-1:0]        mid_row;
    logic [SIDE_MAX-1:0]        dn_row;
    logic [IDX_W-1:0]           c_idx;
    logic [IDX_W-1:0]           lf_idx;
    logic [IDX_W-1:0]           rt_idx;
    logic [2:0]                 ups;
    logic                       cur;
    logic [3:0]                 thr_idx;
    logic [THR_W-1:0]           thr_sel;
    logic [DRAW_W-1:0]          draw_m;
    logic                       go;
    logic                       err;
    logic                       flip;
    logic signed [19:0]         j_ext;
    logic signed [19:0]         sj;
    logic signed [20:0]         t_sum;
    logic signed [22:0]         dh;
    logic signed [ENERGY_W:0]   e_sum;

    // row resolution: bypass of the last write, then valid bit, else all +1
    always_comb
    begin
        if (byp_vld_reg && byp_addr_reg == up_idx)
            up_row = byp_data_reg;
        else if (vld_reg[up_idx])
            up_row = up_q;
        else
            up_row = '1;
        if (byp_vld_reg && byp_addr_reg == mid_idx)
            mid_row = byp_data_reg;
        else if (vld_reg[mid_idx])
            mid_row = mid_q;
        else
            mid_row = '1;
        if (byp_vld_reg && byp_addr_reg == dn_idx)
            dn_row = byp_data_reg;
        else if (vld_reg[dn_idx])
            dn_row = dn_q;
        else
            dn_row = '1;
    end

    // column wrap
    assign c_idx  = IDX_W'(item.col);
    assign lf_idx = (c_idx == '0) ? IDX_W'(side - SIDE_W'(1)) : c_idx - IDX_W'(1);
    assign rt_idx = (SIDE_W'(c_idx) + SIDE_W'(1) == side) ? '0 : c_idx + IDX_W'(1);

    // neighbour count and flip decision
    assign ups     = {2'b00, up_row[c_idx]} + {2'b00, dn_row[c_idx]}
                   + {2'b00, mid_row[lf_idx]} + {2'b00, mid_row[rt_idx]};
    assign cur     = mid_row[c_idx];
    assign thr_idx = (cur ? 4'd0 : 4'd5) + {1'b0, ups};
    assign thr_sel = cfg.thr[thr_idx];
    assign draw_m  = item.random_draw & DRAW_MASK;
    assign err     = (CMP_W'(item.row) >= CMP_W'(side)) || (CMP_W'(item.col) >= CMP_W'(side));
    assign go      = (item.kind == KIND_SET) ? (item.spin_value != cur)
                                             : ({1'b0, draw_m} < thr_sel);
    assign flip    = go && !err;

    // energy step 2*s*(S*J + B)
    assign j_ext = 20'(cfg.coupling_j);
    always_comb
    begin
        case (ups)
            3'd0:    sj = -(j_ext <<< 2);
            3'd1:    sj = -(j_ext <<< 1);
            3'd2:    sj = '0;
            3'd3:    sj = j_ext <<< 1;
            default: sj = j_ext <<< 2;
        endcase
    end
    assign t_sum = 21'(sj) + 21'(cfg.field_b);
    assign dh    = cur ? (23'(t_sum) <<< 1) : -(23'(t_sum) <<< 1);
    assign e_sum = (ENERGY_W+1)'(energy_reg) + (ENERGY_W+1)'(dh);

    // saturating accumulate
    always_comb
    begin
        if (e_sum[ENERGY_W] != e_sum[ENERGY_W-1])
            energy_next = e_sum[ENERGY_W] ? E_MIN : E_MAX;
        else
            energy_next = e_sum[ENERGY_W-1:0];
    end

    // down spin count
    always_comb
    begin
        if (cur)
            down_next = down_reg + CNT_W'(1);
        else if (down_reg != '0)
            down_next = down_reg - CNT_W'(1);
        else
            down_next = down_reg;
    end

    // row write back
    assign row_we    = fire && flip;
    assign row_waddr = mid_idx;
    assign row_wdata = mid_row ^ (SIDE_MAX'(1) << c_idx);

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            byp_vld_reg <= 1'b0;
            down_reg    <= '0;
            energy_reg  <= '0;
        end
        else if (row_we)
        begin
            vld_reg[mid_idx] <= 1'b1;
            byp_vld_reg      <= 1'b1;
            down_reg         <= down_next;
            energy_reg       <= energy_next;
        end
    end

    // bypass payload
    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            byp_addr_reg <= mid_idx;
            byp_data_reg <= row_wdata;
        end
    end

    // result word
    assign result.flipped       = flip;
    assign result.new_spin      = err ? 1'b0 : (cur ^ flip);
    assign result.down_count    = flip ? down_next : down_reg;
    assign result.energy_change = flip ? energy_next : energy_reg;
    assign result.site_error    = err;

`ifndef SYNTHESIS
    // bookkeeping only moves with a write back
    a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
        !row_we |=> $stable(down_reg) && $stable(energy_reg))
        else $error("down count or energy moved without a flip");

    // an up spin flipping down adds one down spin
    a_down_inc: assert property (@(posedge clk) disable iff (!rst_n)
        row_we && cur |=> down_reg == $past(down_reg) + CNT_W'(1))
        else $error("down count did not step on a down flip");

    // an error site never writes the lattice
    a_err_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        err |-> !row_we)
        else $error("lattice written for an out of range site");
`endif

endmodule
`default_nettype wire
